/* rtl/alucc_pkg.sv */
// ----------------------------------------------------------------------------
// alucc_pkg
// Shared widths, operation codes and condition-code bit positions for the
// 8/16-bit arithmetic unit with condition codes.
// ----------------------------------------------------------------------------
package alucc_pkg;

	// field widths
	localparam int KIND_W  = 5;
	localparam int WORD_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int FLAGS_W = 8;
	localparam int SEL_W   = 4;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_NEG    = 5'd0;
	localparam logic [KIND_W-1:0] KIND_COM    = 5'd1;
	localparam logic [KIND_W-1:0] KIND_LSR    = 5'd2;
	localparam logic [KIND_W-1:0] KIND_ROR    = 5'd3;
	localparam logic [KIND_W-1:0] KIND_ASR    = 5'd4;
	localparam logic [KIND_W-1:0] KIND_ASL    = 5'd5;
	localparam logic [KIND_W-1:0] KIND_ROL    = 5'd6;
	localparam logic [KIND_W-1:0] KIND_DEC    = 5'd7;
	localparam logic [KIND_W-1:0] KIND_INC    = 5'd8;
	localparam logic [KIND_W-1:0] KIND_TST    = 5'd9;
	localparam logic [KIND_W-1:0] KIND_CLR    = 5'd10;
	localparam logic [KIND_W-1:0] KIND_SUB    = 5'd11;
	localparam logic [KIND_W-1:0] KIND_SBC    = 5'd12;
	localparam logic [KIND_W-1:0] KIND_AND    = 5'd13;
	localparam logic [KIND_W-1:0] KIND_LD     = 5'd14;
	localparam logic [KIND_W-1:0] KIND_EOR    = 5'd15;
	localparam logic [KIND_W-1:0] KIND_ADC    = 5'd16;
	localparam logic [KIND_W-1:0] KIND_OR     = 5'd17;
	localparam logic [KIND_W-1:0] KIND_ADD    = 5'd18;
	localparam logic [KIND_W-1:0] KIND_SUB16  = 5'd19;
	localparam logic [KIND_W-1:0] KIND_LD16   = 5'd20;
	localparam logic [KIND_W-1:0] KIND_ADD16  = 5'd21;
	localparam logic [KIND_W-1:0] KIND_BRANCH = 5'd22;

	// condition-code bit positions
	localparam int FLAG_C = 0;
	localparam int FLAG_V = 1;
	localparam int FLAG_Z = 2;
	localparam int FLAG_N = 3;
	localparam int FLAG_H = 5;

	// branch condition selectors (bits 3..1 of the branch opcode nibble)
	localparam logic [2:0] COND_ALWAYS = 3'd0;
	localparam logic [2:0] COND_HI     = 3'd1;
	localparam logic [2:0] COND_CC     = 3'd2;
	localparam logic [2:0] COND_NE     = 3'd3;
	localparam logic [2:0] COND_VC     = 3'd4;
	localparam logic [2:0] COND_PL     = 3'd5;
	localparam logic [2:0] COND_GE     = 3'd6;
	localparam logic [2:0] COND_GT     = 3'd7;

endpackage

/* rtl/alucc_cmd_if.sv */
// ----------------------------------------------------------------------------
// alucc_cmd_if
// Valid/ready channel carrying one operation request to the arithmetic unit.
// ----------------------------------------------------------------------------
interface alucc_cmd_if;

	logic                                valid;
	logic                                ready;
	logic [alucc_pkg::KIND_W-1:0]        kind;
	logic [alucc_pkg::WORD_W-1:0]        operand_a;
	logic [alucc_pkg::WORD_W-1:0]        operand_b;
	logic [alucc_pkg::FLAGS_W-1:0]       flags_in;
	logic [alucc_pkg::SEL_W-1:0]         branch_select;

	modport source (
		output valid, kind, operand_a, operand_b, flags_in, branch_select,
		input  ready
	);

	modport sink (
		input  valid, kind, operand_a, operand_b, flags_in, branch_select,
		output ready
	);

endinterface

/* rtl/alucc_res_if.sv */
// ----------------------------------------------------------------------------
// alucc_res_if
// Valid/ready channel carrying one result of the arithmetic unit.
// ----------------------------------------------------------------------------
interface alucc_res_if;

	logic                                valid;
	logic                                ready;
	logic [alucc_pkg::WORD_W-1:0]        value_out;
	logic [alucc_pkg::FLAGS_W-1:0]       flags_out;
	logic                                branch_taken;

	modport source (
		output valid, value_out, flags_out, branch_taken,
		input  ready
	);

	modport sink (
		input  valid, value_out, flags_out, branch_taken,
		output ready
	);

endinterface

/* rtl/cpu_alu_with_condition_codes.sv */
// ----------------------------------------------------------------------------
// cpu_alu_with_condition_codes
// 8/16-bit arithmetic unit with 6809-style condition codes and branch test.
// ----------------------------------------------------------------------------
// path: an accepted cmd transaction passes the input register, then the result register, to its res transaction
// throughput: one transaction per cycle while res is not stalled; input register feeds the ALU logic,
// which feeds the result register; the input register advances when it is empty or the result register does
// a stalled result register holds while an empty input register can still fill
// reset: arst_n clears both stage valid bits; the payload registers are not reset
module cpu_alu_with_condition_codes (
	input  logic        clk,
	input  logic        arst_n,
	alucc_cmd_if.sink   cmd,
	alucc_res_if.source res
);

	// stage 1: input register
	logic                                valid_s1;
	logic [alucc_pkg::KIND_W-1:0]        kind_s1;
	logic [alucc_pkg::WORD_W-1:0]        a_s1;
	logic [alucc_pkg::WORD_W-1:0]        b_s1;
	logic [alucc_pkg::FLAGS_W-1:0]       flags_s1;
	logic [alucc_pkg::SEL_W-1:0]         sel_s1;

	// stage 2: result register
	logic                                valid_s2;
	logic [alucc_pkg::WORD_W-1:0]        value_s2;
	logic [alucc_pkg::FLAGS_W-1:0]       flags_s2;
	logic                                taken_s2;

	// handshake
	logic adv_s2;
	logic adv_s1;

	// ALU datapath
	logic [alucc_pkg::BYTE_W-1:0]        a8;
	logic [alucc_pkg::BYTE_W-1:0]        b8;
	logic                                cin;
	logic [alucc_pkg::BYTE_W:0]          sub_amt;
	logic [alucc_pkg::BYTE_W:0]          dif9;
	logic [alucc_pkg::BYTE_W:0]          sum9;
	logic [alucc_pkg::WORD_W:0]          dif17;
	logic [alucc_pkg::WORD_W:0]          sum17;
	logic                                cond;
	logic [alucc_pkg::BYTE_W-1:0]        r8;
	logic [alucc_pkg::WORD_W-1:0]        r16;
	logic [alucc_pkg::WORD_W-1:0]        value_d;
	logic [alucc_pkg::FLAGS_W-1:0]       flags_d;
	logic                                taken_d;

	// pipeline flow control
	assign adv_s2    = ~valid_s2 | res.ready;
	assign adv_s1    = ~valid_s1 | adv_s2;
	assign cmd.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= cmd.valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (adv_s1 && cmd.valid) begin
			kind_s1  <= cmd.kind;
			a_s1     <= cmd.operand_a;
			b_s1     <= cmd.operand_b;
			flags_s1 <= cmd.flags_in;
			sel_s1   <= cmd.branch_select;
		end
	end

	// shared adders
	assign a8      = a_s1[alucc_pkg::BYTE_W-1:0];
	assign b8      = b_s1[alucc_pkg::BYTE_W-1:0];
	assign cin     = flags_s1[alucc_pkg::FLAG_C];
	assign sub_amt = {1'b0, b8} + {8'h00, (kind_s1 == alucc_pkg::KIND_SBC) & cin};
	assign dif9    = {1'b0, a8} - sub_amt;
	assign sum9    = {1'b0, a8} + {1'b0, b8} + {8'h00, (kind_s1 == alucc_pkg::KIND_ADC) & cin};
	assign dif17   = {1'b0, a_s1} - {1'b0, b_s1};
	assign sum17   = {1'b0, a_s1} + {1'b0, b_s1};

	// branch condition
	always_comb begin
		case (sel_s1[3:1])
			alucc_pkg::COND_HI: cond = ~(flags_s1[alucc_pkg::FLAG_Z] | cin);
			alucc_pkg::COND_CC: cond = ~cin;
			alucc_pkg::COND_NE: cond = ~flags_s1[alucc_pkg::FLAG_Z];
			alucc_pkg::COND_VC: cond = ~flags_s1[alucc_pkg::FLAG_V];
			alucc_pkg::COND_PL: cond = ~flags_s1[alucc_pkg::FLAG_N];
			alucc_pkg::COND_GE: cond = flags_s1[alucc_pkg::FLAG_N] ==
				flags_s1[alucc_pkg::FLAG_V];
			alucc_pkg::COND_GT: cond = ~flags_s1[alucc_pkg::FLAG_Z] &
				(flags_s1[alucc_pkg::FLAG_N] == flags_s1[alucc_pkg::FLAG_V]);
			default:            cond = 1'b1;
		endcase
	end

	// operation select and flag update
	always_comb begin
		r8      = '0;
		r16     = '0;
		value_d = '0;
		flags_d = flags_s1;
		taken_d = 1'b0;
		case (kind_s1) inside
			alucc_pkg::KIND_NEG: begin
				r8 = 8'h00 - a8;
				flags_d[alucc_pkg::FLAG_V] = (a8 == 8'h80);
				flags_d[alucc_pkg::FLAG_C] = |a8;
			end
			alucc_pkg::KIND_COM: begin
				r8 = ~a8;
				flags_d[alucc_pkg::FLAG_V] = 1'b0;
				flags_d[alucc_pkg::FLAG_C] = 1'b1;
			end
			alucc_pkg::KIND_LSR, alucc_pkg::KIND_ROR, alucc_pkg::KIND_ASR: begin
				if (kind_s1 == alucc_pkg::KIND_ROR) r8 = {cin, a8[7:1]};
				else if (kind_s1 == alucc_pkg::KIND_ASR) r8 = {a8[7], a8[7:1]};
				else r8 = {1'b0, a8[7:1]};
				flags_d[alucc_pkg::FLAG_C] = a8[0];
			end
			alucc_pkg::KIND_ASL, alucc_pkg::KIND_ROL: begin
				r8 = {a8[6:0], (kind_s1 == alucc_pkg::KIND_ROL) & cin};
				flags_d[alucc_pkg::FLAG_V] = a8[7] ^ a8[6];
				flags_d[alucc_pkg::FLAG_C] = a8[7];
			end
			alucc_pkg::KIND_DEC: begin
				r8 = a8 - 8'h01;
				flags_d[alucc_pkg::FLAG_V] = (r8 == 8'h7f);
			end
			alucc_pkg::KIND_INC: begin
				r8 = a8 + 8'h01;
				flags_d[alucc_pkg::FLAG_V] = (r8 == 8'h80);
			end
			alucc_pkg::KIND_TST: begin
				r8 = a8;
				flags_d[alucc_pkg::FLAG_V] = 1'b0;
			end
			alucc_pkg::KIND_CLR: begin
				r8 = '0;
				flags_d[alucc_pkg::FLAG_V] = 1'b0;
				flags_d[alucc_pkg::FLAG_C] = 1'b0;
			end
			alucc_pkg::KIND_SUB, alucc_pkg::KIND_SBC: begin
				r8 = dif9[7:0];
				flags_d[alucc_pkg::FLAG_V] = (a8[7] ^ b8[7]) & (a8[7] ^ r8[7]);
				flags_d[alucc_pkg::FLAG_C] = dif9[8];
			end
			alucc_pkg::KIND_AND, alucc_pkg::KIND_LD, alucc_pkg::KIND_EOR,
			alucc_pkg::KIND_OR: begin
				if (kind_s1 == alucc_pkg::KIND_AND) r8 = a8 & b8;
				else if (kind_s1 == alucc_pkg::KIND_LD) r8 = b8;
				else if (kind_s1 == alucc_pkg::KIND_EOR) r8 = a8 ^ b8;
				else r8 = a8 | b8;
				flags_d[alucc_pkg::FLAG_V] = 1'b0;
			end
			alucc_pkg::KIND_ADC, alucc_pkg::KIND_ADD: begin
				r8 = sum9[7:0];
				flags_d[alucc_pkg::FLAG_V] = ~(a8[7] ^ b8[7]) & (a8[7] ^ r8[7]);
				flags_d[alucc_pkg::FLAG_C] = sum9[8];
				flags_d[alucc_pkg::FLAG_H] = a8[4] ^ b8[4] ^ r8[4];
			end
			alucc_pkg::KIND_SUB16: begin
				r16 = dif17[15:0];
				flags_d[alucc_pkg::FLAG_V] = (a_s1[15] ^ b_s1[15]) & (a_s1[15] ^ r16[15]);
				flags_d[alucc_pkg::FLAG_C] = dif17[16];
			end
			alucc_pkg::KIND_LD16: begin
				r16 = b_s1;
				flags_d[alucc_pkg::FLAG_V] = 1'b0;
			end
			alucc_pkg::KIND_ADD16: begin
				r16 = sum17[15:0];
				flags_d[alucc_pkg::FLAG_V] = ~(a_s1[15] ^ b_s1[15]) & (a_s1[15] ^ r16[15]);
				flags_d[alucc_pkg::FLAG_C] = sum17[16];
			end
			alucc_pkg::KIND_BRANCH: begin
				taken_d = cond ^ sel_s1[0];
			end
			default: begin
			end
		endcase

		// N and Z from the 8-bit or 16-bit result
		if (kind_s1 <= alucc_pkg::KIND_ADD) begin
			value_d = {8'h00, r8};
			flags_d[alucc_pkg::FLAG_N] = r8[7];
			flags_d[alucc_pkg::FLAG_Z] = (r8 == 8'h00);
		end else if (kind_s1 <= alucc_pkg::KIND_ADD16) begin
			value_d = r16;
			flags_d[alucc_pkg::FLAG_N] = r16[15];
			flags_d[alucc_pkg::FLAG_Z] = (r16 == 16'h0000);
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			value_s2 <= value_d;
			flags_s2 <= flags_d;
			taken_s2 <= taken_d;
		end
	end

	assign res.valid        = valid_s2;
	assign res.value_out    = value_s2;
	assign res.flags_out    = flags_s2;
	assign res.branch_taken = taken_s2;

endmodule
